// ----- rtl/core/msx_pkg.sv -----
// Shared types and constants for the mask row span extractor.
// Register map, configuration bundle and the job record passed from front to back.
// No dependencies.
`default_nettype none

package msx_pkg;

   // Field widths fixed by the register map and the span format
   localparam int COL_W       = 13;
   localparam int ROW_W       = 13;
   localparam int BYTE_W      = 8;
   localparam int POS_W       = 3;
   localparam int STRIDE_W    = 16;
   localparam int ORIGIN_W    = 16;
   localparam int COORD_W     = 17;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;

   // Byte counter saturation value
   localparam logic [STRIDE_W-1:0] BYTE_CNT_MAX = 16'hffff;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_WIDTH   = 3'd0,
      CSR_ROW_COUNT   = 3'd1,
      CSR_BIT_OFFSET  = 3'd2,
      CSR_ROW_STRIDE  = 3'd3,
      CSR_INVERT_MASK = 3'd4,
      CSR_X_ORIGIN    = 3'd5,
      CSR_Y_ORIGIN    = 3'd6
   } csr_index_type;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [COL_W-1:0]           row_width;
      logic [ROW_W-1:0]           row_count;
      logic [POS_W-1:0]           bit_offset;
      logic [STRIDE_W-1:0]        row_stride;
      logic                       invert_mask;
      logic signed [ORIGIN_W-1:0] x_origin;
      logic signed [ORIGIN_W-1:0] y_origin;
   } cfg_type;

   // One byte's worth of span work: close/start pixel positions inside the byte,
   // plus an optional end-of-row close.
   typedef struct packed {
      logic [BYTE_W-1:0] closes;
      logic [BYTE_W-1:0] starts;
      logic [COL_W-1:0]  col;
      logic [POS_W-1:0]  k0;
      logic [COL_W-1:0]  open_start;
      logic              fin;
      logic [COL_W-1:0]  fin_start;
      logic [COL_W-1:0]  fin_end;
      logic              done;
      logic [ROW_W-1:0]  row;
   } job_type;

endpackage

`default_nettype wire

// ----- rtl/core/msx_queue.sv -----
// Small job queue between the byte classifier and the span emitter.
// Depends on msx_pkg (job_type, QUEUE_DEPTH).
`default_nettype none

module msx_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire msx_pkg::job_type push_job,
   output logic                  has_room,
   input  wire logic             pop,
   output logic                  head_valid,
   output msx_pkg::job_type      head_job
);
   import msx_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign has_room   = (count_ff < CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/msx_front.sv -----
// Byte classifier: tracks row position and open run, marks run starts and
// closes within each accepted byte and queues a job when spans result.
// Depends on msx_pkg (cfg_type, job_type, widths).
`default_nettype none

module msx_front #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_ROWS  = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire msx_pkg::cfg_type           cfg,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [msx_pkg::BYTE_W-1:0] req_mask_byte,
   input  wire logic                       q_has_room,
   output logic                            push_valid,
   output msx_pkg::job_type                push_job
);
   import msx_pkg::*;

   // Effective limits: registers are 13 bits wide, so nothing exceeds 8191
   localparam int REG_MAX = (1 << COL_W) - 1;
   localparam int WCAP    = (MAX_WIDTH < REG_MAX) ? MAX_WIDTH : REG_MAX;
   localparam int RCAP    = (MAX_ROWS < REG_MAX) ? MAX_ROWS : REG_MAX;
   localparam int CW      = $clog2(WCAP + 1);
   localparam int RW      = (RCAP > 1) ? $clog2(RCAP) : 1;

   logic [CW-1:0]       column_ff, column_in;
   logic [STRIDE_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [RW-1:0]       row_ff, row_in;
   logic                run_open_ff, run_open_in;
   logic [CW-1:0]       run_start_ff, run_start_in;

   logic                accept;
   logic [BYTE_W-1:0]   pix;
   logic [BYTE_W-1:0]   in_scan;
   logic [BYTE_W-1:0]   prev_pix;
   logic [BYTE_W-1:0]   closes;
   logic [BYTE_W-1:0]   starts;
   logic [POS_W-1:0]    k0;
   logic [POS_W-1:0]    last_pos;
   logic [POS_W-1:0]    last_start_pos;
   logic [CW-1:0]       w;
   logic [CW-1:0]       avail;
   logic [3:0]          n_lim;
   logic [3:0]          n_scan;
   logic [3:0]          scan_end;
   logic [ROW_W-1:0]    rows;
   logic [CW-1:0]       col_next;
   logic [CW-1:0]       start_after;
   logic                open_after;
   logic                row_end;
   logic                last_row;
   logic                stride_hit;
   logic [STRIDE_W-1:0] byte_cnt_inc;

   assign req_ready = q_has_room;
   assign accept    = req_valid && q_has_room;

   // per-byte classification
   always_comb begin
      k0 = (byte_cnt_ff == '0) ? cfg.bit_offset : '0;

      // clamp width and row count
      w = (cfg.row_width > COL_W'(WCAP)) ? CW'(WCAP) : cfg.row_width[CW-1:0];
      if (cfg.row_count == '0) begin
         rows = ROW_W'(1);
      end else if (cfg.row_count > ROW_W'(RCAP)) begin
         rows = ROW_W'(RCAP);
      end else begin
         rows = cfg.row_count;
      end

      // pixels to scan in this byte
      avail    = (column_ff < w) ? (w - column_ff) : '0;
      n_lim    = 4'd8 - {1'b0, k0};
      n_scan   = (avail < CW'(n_lim)) ? 4'(avail) : n_lim;
      scan_end = {1'b0, k0} + n_scan;

      // pixel k is bit 7-k; polarity applied here
      for (int k = 0; k < BYTE_W; k++) begin
         pix[k]     = req_mask_byte[BYTE_W-1-k] ^ cfg.invert_mask;
         in_scan[k] = (4'(k) >= {1'b0, k0}) && (4'(k) < scan_end);
      end

      // left neighbor of each pixel, open-run flag at the first scanned one
      prev_pix[0] = run_open_ff;
      for (int k = 1; k < BYTE_W; k++) begin
         prev_pix[k] = (k0 == POS_W'(k)) ? run_open_ff : pix[k-1];
      end

      closes = in_scan & ~pix & prev_pix;
      starts = in_scan & pix & ~prev_pix;

      // last run start in this byte
      last_start_pos = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         if (starts[k]) begin
            last_start_pos = POS_W'(k);
         end
      end

      last_pos    = POS_W'(scan_end - 4'd1);
      open_after  = (n_scan == '0) ? run_open_ff : pix[last_pos];
      start_after = (starts != '0) ? (column_ff + CW'(last_start_pos - k0)) : run_start_ff;

      col_next     = column_ff + CW'(n_scan);
      row_end      = (col_next >= w);
      last_row     = ((14'(row_ff) + 14'd1) >= {1'b0, rows});
      stride_hit   = ((17'(byte_cnt_ff) + 17'd1) >= {1'b0, cfg.row_stride});
      byte_cnt_inc = (byte_cnt_ff == BYTE_CNT_MAX) ? byte_cnt_ff : (byte_cnt_ff + 1'b1);
   end

   // job record for the span emitter
   always_comb begin
      push_job.closes     = closes;
      push_job.starts     = starts;
      push_job.col        = COL_W'(column_ff);
      push_job.k0         = k0;
      push_job.open_start = COL_W'(run_start_ff);
      push_job.fin        = row_end && open_after;
      push_job.fin_start  = COL_W'(start_after);
      push_job.fin_end    = COL_W'(col_next);
      push_job.done       = last_row;
      push_job.row        = ROW_W'(row_ff);
      push_valid          = accept && ((closes != '0) || (row_end && open_after));
   end

   // position state update
   always_comb begin
      column_in    = column_ff;
      byte_cnt_in  = byte_cnt_ff;
      row_in       = row_ff;
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      if (accept) begin
         if (row_end) begin
            run_open_in  = 1'b0;
            run_start_in = start_after;
            if (stride_hit) begin
               column_in    = '0;
               byte_cnt_in  = '0;
               run_start_in = '0;
               row_in       = last_row ? '0 : (row_ff + 1'b1);
            end else begin
               column_in   = col_next;
               byte_cnt_in = byte_cnt_inc;
            end
         end else begin
            column_in    = col_next;
            byte_cnt_in  = byte_cnt_inc;
            run_open_in  = open_after;
            run_start_in = start_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         byte_cnt_ff  <= '0;
         row_ff       <= '0;
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
      end else begin
         column_ff    <= column_in;
         byte_cnt_ff  <= byte_cnt_in;
         row_ff       <= row_in;
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/msx_back.sv -----
// Span emitter: walks the closes of one queued job, one span per cycle while
// the output is not held, then the end-of-row close, into the output register.
// Depends on msx_pkg (cfg_type, job_type, widths).
`default_nettype none

module msx_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire msx_pkg::cfg_type                   cfg,
   input  wire logic                               q_valid,
   input  wire msx_pkg::job_type                   q_job,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [msx_pkg::COORD_W-1:0]      rsp_span_x,
   output logic signed [msx_pkg::COORD_W-1:0]      rsp_span_y,
   output logic        [msx_pkg::COL_W-1:0]        rsp_span_len,
   output logic                                    rsp_last_of_byte,
   output logic                                    rsp_mask_done
);
   import msx_pkg::*;

   job_type               job_ff, job_in;
   logic                  job_valid_ff, job_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] span_x_ff, span_y_ff;
   logic [COL_W-1:0]      span_len_ff;
   logic                  last_ff, done_ff;

   logic [POS_W-1:0]      close_pos;
   logic [POS_W-1:0]      start_pos;
   logic                  start_found;
   logic                  has_close;
   logic [BYTE_W-1:0]     remaining;
   logic [COL_W-1:0]      span_start;
   logic [COL_W-1:0]      span_end;
   logic                  span_last;
   logic                  span_done;
   logic                  emit;

   // pick the next span of the current job
   always_comb begin
      has_close = (job_ff.closes != '0);
      close_pos = '0;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         if (job_ff.closes[k]) begin
            close_pos = POS_W'(k);
         end
      end

      // run start: latest start left of the close, else the run came in open
      start_found = 1'b0;
      start_pos   = '0;
      for (int j = 0; j < BYTE_W; j++) begin
         if (job_ff.starts[j] && (POS_W'(j) < close_pos)) begin
            start_found = 1'b1;
            start_pos   = POS_W'(j);
         end
      end

      remaining = job_ff.closes & ~(8'b1 << close_pos);

      if (has_close) begin
         span_start = start_found ? (job_ff.col + COL_W'(start_pos - job_ff.k0))
                                  : job_ff.open_start;
         span_end   = job_ff.col + COL_W'(close_pos - job_ff.k0);
         span_last  = (remaining == '0) && !job_ff.fin;
         span_done  = 1'b0;
      end else begin
         span_start = job_ff.fin_start;
         span_end   = job_ff.fin_end;
         span_last  = 1'b1;
         span_done  = job_ff.done;
      end

      emit  = job_valid_ff && (!rsp_valid_ff || rsp_ready);
      q_pop = q_valid && (!job_valid_ff || (emit && span_last));
   end

   // job register update
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      if (q_pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
      end else if (emit && span_last) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         if (has_close) begin
            job_in.closes = remaining;
         end else begin
            job_in.fin = 1'b0;
         end
      end
   end

   // output register handshake
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (emit) begin
         span_x_ff   <= {cfg.x_origin[ORIGIN_W-1], cfg.x_origin} + {4'b0, span_start};
         span_y_ff   <= {cfg.y_origin[ORIGIN_W-1], cfg.y_origin} + {4'b0, job_ff.row};
         span_len_ff <= span_end - span_start;
         last_ff     <= span_last;
         done_ff     <= span_done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_span_x       = span_x_ff;
   assign rsp_span_y       = span_y_ff;
   assign rsp_span_len     = span_len_ff;
   assign rsp_last_of_byte = last_ff;
   assign rsp_mask_done    = done_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mask_row_span_extractor_top.sv -----
// Mask row span extractor: turns a 1 bpp mask byte stream into row spans.
//
// Channels: req_ carries mask bytes (leftmost pixel in bit 7), rsp_ carries
// spans (x, y, length, last span of its byte, end of mask), csr_ writes the
// seven setup registers by index. All use valid/ready; a beat moves on an edge
// with both high. csr_ready is always high; write only while the block is idle.
// Throughput: one byte per cycle while each byte closes at most one run and
// rsp_ takes every span; a byte that closes more runs holds the span emitter
// for one span per run (up to five). A four-entry job queue between classifier
// and emitter absorbs bursts. A byte's spans pass from the job queue through
// the job register into the output register before they reach rsp_.
// Reset: position goes to row 0, column 0 with no open run, the queue and
// output empty, registers to width 1, rows 1, stride 1, the rest zero.
// Stall: a held rsp_ beat freezes the emitter; the queue fills and req_ready
// drops once four jobs wait. Bytes that yield no span never enter the queue.
// Depends on msx_pkg, msx_front, msx_queue, msx_back.
`default_nettype none

module mask_row_span_extractor_top #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_ROWS  = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [msx_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [msx_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // mask bytes
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [msx_pkg::BYTE_W-1:0]          req_mask_byte,
   // spans
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [msx_pkg::COORD_W-1:0]       rsp_span_x,
   output logic signed [msx_pkg::COORD_W-1:0]       rsp_span_y,
   output logic        [msx_pkg::COL_W-1:0]         rsp_span_len,
   output logic                                     rsp_last_of_byte,
   output logic                                     rsp_mask_done
);
   import msx_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push_valid;
   job_type push_job;
   logic    q_has_room;
   logic    q_pop;
   logic    q_valid;
   job_type q_job;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_WIDTH:   cfg_in.row_width   = csr_wdata[COL_W-1:0];
            CSR_ROW_COUNT:   cfg_in.row_count   = csr_wdata[ROW_W-1:0];
            CSR_BIT_OFFSET:  cfg_in.bit_offset  = csr_wdata[POS_W-1:0];
            CSR_ROW_STRIDE:  cfg_in.row_stride  = csr_wdata[STRIDE_W-1:0];
            CSR_INVERT_MASK: cfg_in.invert_mask = csr_wdata[0];
            CSR_X_ORIGIN:    cfg_in.x_origin    = csr_wdata[ORIGIN_W-1:0];
            CSR_Y_ORIGIN:    cfg_in.y_origin    = csr_wdata[ORIGIN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_width   <= COL_W'(1);
         cfg_ff.row_count   <= ROW_W'(1);
         cfg_ff.bit_offset  <= '0;
         cfg_ff.row_stride  <= STRIDE_W'(1);
         cfg_ff.invert_mask <= 1'b0;
         cfg_ff.x_origin    <= '0;
         cfg_ff.y_origin    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msx_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_ROWS  (MAX_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mask_byte (req_mask_byte),
      .q_has_room    (q_has_room),
      .push_valid    (push_valid),
      .push_job      (push_job)
   );

   msx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .has_room   (q_has_room),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_job)
   );

   msx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_job            (q_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_span_x       (rsp_span_x),
      .rsp_span_y       (rsp_span_y),
      .rsp_span_len     (rsp_span_len),
      .rsp_last_of_byte (rsp_last_of_byte),
      .rsp_mask_done    (rsp_mask_done)
   );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for mask_row_span_extractor_top: drives mask bytes and register writes,
// predicts spans from its own scan model or takes them from the directed table, checks each rsp_ beat.
// Depends on msx_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb;
   import msx_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_ROWS      = 4096;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BYTES   = 24;
   localparam int WIDE_BYTES    = 72;
   localparam int STALL_CYCLES  = 250;

   // Index with no register behind it; the byte rows of the table carry NO_REG
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] NO_REG     = 3'd0;

   // One span as seen on the rsp_ channel
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COL_W-1:0]          len;
      logic                      last_of_byte;
      logic                      mask_done;
   } span_type;

   // Directed rows: a register write, or a byte with its spans predicted,
   // known to give none, or known to give exactly the span in the row
   typedef enum logic [1:0] {STEP_REG, STEP_BYTE, STEP_NO_SPAN, STEP_ONE_SPAN} step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      span_type              span;
   } step_type;

   localparam span_type NO_SPAN     = '0;
   localparam span_type PIXEL_SPAN  = '{17'sd0, 17'sd0, 13'd1, 1'b1, 1'b1};
   localparam span_type CORNER_SPAN = '{17'sd32767, -17'sd32768, 13'd8, 1'b1, 1'b1};

   localparam step_type DIRECTED_STEPS [0:38] = '{
      // reset setup: width 1, one row, stride 1
      '{STEP_ONE_SPAN, NO_REG, 16'h0080, PIXEL_SPAN},
      '{STEP_NO_SPAN,  NO_REG, 16'h007f, NO_SPAN},
      '{STEP_ONE_SPAN, NO_REG, 16'h00ff, PIXEL_SPAN},
      // width 8, origins at opposite extremes
      '{STEP_REG, CSR_ROW_WIDTH,  16'd8,     NO_SPAN},
      '{STEP_REG, CSR_X_ORIGIN,   16'h7fff,  NO_SPAN},
      '{STEP_REG, CSR_Y_ORIGIN,   16'h8000,  NO_SPAN},
      '{STEP_ONE_SPAN, NO_REG, 16'h00ff, CORNER_SPAN},
      '{STEP_BYTE, NO_REG, 16'h00aa, NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h0055, NO_SPAN},
      // two rows of 16: a run carried across bytes, then five spans from one byte
      '{STEP_REG, CSR_ROW_WIDTH,  16'd16,    NO_SPAN},
      '{STEP_REG, CSR_ROW_STRIDE, 16'd2,     NO_SPAN},
      '{STEP_REG, CSR_ROW_COUNT,  16'd2,     NO_SPAN},
      '{STEP_REG, CSR_X_ORIGIN,   16'h8000,  NO_SPAN},
      '{STEP_REG, CSR_Y_ORIGIN,   16'h7fff,  NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h0001, NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h0055, NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h00ff, NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h00ff, NO_SPAN},
      // inverted mask, row count zero
      '{STEP_REG, CSR_INVERT_MASK, 16'd1,    NO_SPAN},
      '{STEP_REG, CSR_ROW_COUNT,  16'd0,     NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h0000, NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h00f0, NO_SPAN},
      // row starting at the last bit, stride zero
      '{STEP_REG, CSR_INVERT_MASK, 16'd0,    NO_SPAN},
      '{STEP_REG, CSR_ROW_WIDTH,  16'd8,     NO_SPAN},
      '{STEP_REG, CSR_BIT_OFFSET, 16'd7,     NO_SPAN},
      '{STEP_REG, CSR_ROW_STRIDE, 16'd0,     NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h0001, NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h00fe, NO_SPAN},
      // widest stride, then cut short in the middle of the row
      '{STEP_REG, CSR_BIT_OFFSET, 16'd0,     NO_SPAN},
      '{STEP_REG, CSR_ROW_STRIDE, 16'hffff,  NO_SPAN},
      '{STEP_REG, CSR_ROW_COUNT,  16'd2,     NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h00f0, NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h00ff, NO_SPAN},
      '{STEP_REG, CSR_ROW_STRIDE, 16'd1,     NO_SPAN},
      '{STEP_NO_SPAN, NO_REG, 16'h0081, NO_SPAN},
      '{STEP_BYTE, NO_REG, 16'h000f, NO_SPAN},
      // zero width scans nothing; unused index is ignored
      '{STEP_REG, CSR_ROW_WIDTH,  16'd0,     NO_SPAN},
      '{STEP_NO_SPAN, NO_REG, 16'h00ff, NO_SPAN},
      '{STEP_REG, CSR_UNUSED,     16'hffff,  NO_SPAN}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_mask_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic signed [COORD_W-1:0] rsp_span_x;
   logic signed [COORD_W-1:0] rsp_span_y;
   logic [COL_W-1:0]      rsp_span_len;
   logic                  rsp_last_of_byte;
   logic                  rsp_mask_done;

   // Scan model state and its copy of the registers
   cfg_type    mask_setup;
   int         scan_column;
   int         row_byte_count;
   int         cur_row;
   bit         run_active;
   int         run_first_col;
   span_type   byte_spans[$];
   span_type   pending_spans[$];

   // What the byte now on req_ is known to give
   step_kind_type expect_kind;
   span_type      expect_span;

   int send_idle_pct;
   int recv_idle_pct;
   int rsp_hold_left;
   int cycle_count;
   int error_count;
   int bytes_taken;
   int spans_checked;
   int masks_ended;
   int most_spans;

   mask_row_span_extractor_top #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_ROWS (MAX_ROWS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mask_byte   (req_mask_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_span_x      (rsp_span_x),
      .rsp_span_y      (rsp_span_y),
      .rsp_span_len    (rsp_span_len),
      .rsp_last_of_byte(rsp_last_of_byte),
      .rsp_mask_done   (rsp_mask_done)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Span at the current row from column first up to (not including) stop
   function automatic span_type make_span(input int first, input int stop, input bit done);
      span_type s;
      int       xi;
      int       yi;
      xi = $signed(mask_setup.x_origin) + first;
      yi = $signed(mask_setup.y_origin) + cur_row;
      s.x = xi[COORD_W-1:0];
      s.y = yi[COORD_W-1:0];
      s.len = COL_W'(stop - first);
      s.last_of_byte = 1'b0;
      s.mask_done = done;
      return s;
   endfunction

   // Scan one mask byte: advance column/row position, collect closed runs
   task automatic predict_byte(input logic [BYTE_W-1:0] mb);
      int                w;
      int                rows;
      int                k;
      logic [BYTE_W-1:0] b;
      bit                last_row;
      byte_spans.delete();
      w = (int'(mask_setup.row_width) > MAX_WIDTH) ? MAX_WIDTH : int'(mask_setup.row_width);
      rows = (mask_setup.row_count == 0) ? 1 : int'(mask_setup.row_count);
      if (rows > MAX_ROWS) rows = MAX_ROWS;
      b = mask_setup.invert_mask ? ~mb : mb;
      k = (row_byte_count == 0) ? int'(mask_setup.bit_offset) : 0;
      while (k < 8 && scan_column < w) begin
         if (b[7-k] && !run_active) begin
            run_active = 1'b1;
            run_first_col = scan_column;
         end else if (!b[7-k] && run_active) begin
            byte_spans.push_back(make_span(run_first_col, scan_column, 1'b0));
            run_active = 1'b0;
         end
         scan_column++;
         k++;
      end
      // end of row: close an open run, move on once the stride is used up
      if (scan_column >= w) begin
         last_row = (cur_row + 1 >= rows);
         if (run_active) begin
            byte_spans.push_back(make_span(run_first_col, scan_column, last_row));
            run_active = 1'b0;
         end
         if (row_byte_count + 1 >= int'(mask_setup.row_stride)) begin
            scan_column = 0;
            row_byte_count = 0;
            run_first_col = 0;
            cur_row = last_row ? 0 : cur_row + 1;
         end else if (row_byte_count < int'(BYTE_CNT_MAX)) begin
            row_byte_count++;
         end
      end else if (row_byte_count < int'(BYTE_CNT_MAX)) begin
         row_byte_count++;
      end
      if (byte_spans.size() > 0) byte_spans[byte_spans.size()-1].last_of_byte = 1'b1;
   endtask

   // Scoreboard: config and byte beats update the model, span beats are checked
   always @(posedge clock) begin : scoreboard
      span_type got;
      span_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_span_x, rsp_span_y, rsp_span_len, rsp_last_of_byte, rsp_mask_done};
            if (pending_spans.size() == 0) begin
               $error("span with nothing expected: x=%0d y=%0d len=%0d",
                      got.x, got.y, got.len);
               error_count++;
            end else begin
               want = pending_spans.pop_front();
               spans_checked++;
               if (got.mask_done) masks_ended++;
               if (got.x !== want.x) begin
                  $error("span_x: expected %0d, actual %0d", want.x, got.x);
                  error_count++;
               end
               if (got.y !== want.y) begin
                  $error("span_y: expected %0d, actual %0d", want.y, got.y);
                  error_count++;
               end
               if (got.len !== want.len) begin
                  $error("span_len: expected %0d, actual %0d", want.len, got.len);
                  error_count++;
               end
               if (got.last_of_byte !== want.last_of_byte) begin
                  $error("last_of_byte: expected %0d, actual %0d",
                         want.last_of_byte, got.last_of_byte);
                  error_count++;
               end
               if (got.mask_done !== want.mask_done) begin
                  $error("mask_done: expected %0d, actual %0d", want.mask_done, got.mask_done);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROW_WIDTH:   mask_setup.row_width   = csr_wdata[COL_W-1:0];
               CSR_ROW_COUNT:   mask_setup.row_count   = csr_wdata[ROW_W-1:0];
               CSR_BIT_OFFSET:  mask_setup.bit_offset  = csr_wdata[POS_W-1:0];
               CSR_ROW_STRIDE:  mask_setup.row_stride  = csr_wdata[STRIDE_W-1:0];
               CSR_INVERT_MASK: mask_setup.invert_mask = csr_wdata[0];
               CSR_X_ORIGIN:    mask_setup.x_origin    = csr_wdata;
               CSR_Y_ORIGIN:    mask_setup.y_origin    = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_byte(req_mask_byte);
            bytes_taken++;
            if (byte_spans.size() > most_spans) most_spans = byte_spans.size();
            case (expect_kind)
               STEP_NO_SPAN:  ;
               STEP_ONE_SPAN: pending_spans.push_back(expect_span);
               default:       foreach (byte_spans[j]) pending_spans.push_back(byte_spans[j]);
            endcase
         end
      end
   end

   // Receiver: long hold-off when asked, otherwise random back-pressure
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // One byte beat, with random gaps in front of it
   task automatic send_mask_byte(input logic [BYTE_W-1:0] b,
                                 input step_kind_type kind = STEP_BYTE,
                                 input span_type span = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mask_byte <= b;
      expect_kind = kind;
      expect_span = span;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop sending, wait out every expected span plus the pipeline depth
   task automatic wait_spans_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_spans.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Mix of plain random bytes, solid bytes, alternating bits and single edges
   function automatic logic [BYTE_W-1:0] pick_mask_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return $urandom_range(1) ? 8'haa : 8'h55;
         3, 4:    return 8'hff >> $urandom_range(7);
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      int phase;
      int n;
      int w_pick;
      int off_pick;
      int need;
      int stride_pick;

      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_mask_byte = '0;
      rsp_ready = 1'b0;
      rsp_hold_left = 0;
      expect_kind = STEP_BYTE;
      expect_span = '0;
      cycle_count = 0;
      error_count = 0;
      bytes_taken = 0;
      spans_checked = 0;
      masks_ended = 0;
      most_spans = 0;

      // model state after reset
      mask_setup = '0;
      mask_setup.row_width = 1;
      mask_setup.row_count = 1;
      mask_setup.row_stride = 1;
      scan_column = 0;
      row_byte_count = 0;
      cur_row = 0;
      run_active = 1'b0;
      run_first_col = 0;

      send_idle_pct = 17;
      recv_idle_pct = 80;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_STEPS[i]) begin
         if (DIRECTED_STEPS[i].kind == STEP_REG) begin
            wait_spans_drained();
            write_reg(DIRECTED_STEPS[i].idx, DIRECTED_STEPS[i].data);
         end else begin
            send_mask_byte(DIRECTED_STEPS[i].data[BYTE_W-1:0], DIRECTED_STEPS[i].kind,
                           DIRECTED_STEPS[i].span);
         end
      end

      // random phases, each with a fresh setup written while idle
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 4) begin
            send_idle_pct = 80;
            recv_idle_pct = 17;
         end else if (phase == 7) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_spans_drained();
         case ($urandom_range(9))
            0:       w_pick = 0;
            1:       w_pick = $urandom_range(1, 8);
            2:       w_pick = $urandom_range(49, 200);
            default: w_pick = $urandom_range(1, 48);
         endcase
         off_pick = $urandom_range(7);
         need = (off_pick + w_pick + 7) / 8;
         case ($urandom_range(5))
            0:       stride_pick = 0;
            1:       stride_pick = $urandom_range(1, need);
            default: stride_pick = need + $urandom_range(2);
         endcase
         // where the upper bits above a register's width are random, they must be dropped
         write_reg(CSR_ROW_WIDTH, {3'($urandom_range(7)), 13'(w_pick)});
         case ($urandom_range(7))
            0:       write_reg(CSR_ROW_COUNT, {3'($urandom_range(7)), 13'd0});
            1:       write_reg(CSR_ROW_COUNT, {3'($urandom_range(7)), 13'h1fff});
            default: write_reg(CSR_ROW_COUNT, 16'($urandom_range(1, 4)));
         endcase
         write_reg(CSR_BIT_OFFSET, {13'($urandom), 3'(off_pick)});
         write_reg(CSR_ROW_STRIDE, 16'(stride_pick));
         write_reg(CSR_INVERT_MASK, {15'($urandom), 1'($urandom_range(1))});
         case ($urandom_range(3))
            0:       write_reg(CSR_X_ORIGIN, 16'h7fff);
            1:       write_reg(CSR_X_ORIGIN, 16'h8000);
            default: write_reg(CSR_X_ORIGIN, 16'($urandom));
         endcase
         case ($urandom_range(3))
            0:       write_reg(CSR_Y_ORIGIN, 16'h8000);
            1:       write_reg(CSR_Y_ORIGIN, 16'h7fff);
            default: write_reg(CSR_Y_ORIGIN, 16'($urandom));
         endcase
         for (n = 0; n < PHASE_BYTES; n++) send_mask_byte(pick_mask_byte());

         // back-pressure: hold rsp_ off while span-heavy bytes keep coming
         if (phase == 5) begin
            wait_spans_drained();
            write_reg(CSR_ROW_WIDTH, 16'd64);
            write_reg(CSR_ROW_STRIDE, 16'd8);
            write_reg(CSR_ROW_COUNT, 16'd4);
            write_reg(CSR_BIT_OFFSET, 16'd0);
            write_reg(CSR_INVERT_MASK, 16'd0);
            @(posedge clock);
            rsp_hold_left = STALL_CYCLES;
            for (n = 0; n < 48; n++) send_mask_byte(n[0] ? 8'h55 : 8'haa);
         end
      end

      // widest row and most rows written above their caps; long runs across bytes
      wait_spans_drained();
      write_reg(CSR_ROW_WIDTH, 16'hffff);
      write_reg(CSR_ROW_COUNT, 16'hffff);
      write_reg(CSR_BIT_OFFSET, 16'd0);
      write_reg(CSR_ROW_STRIDE, 16'd1);
      write_reg(CSR_INVERT_MASK, 16'd0);
      for (n = 0; n < WIDE_BYTES; n++) send_mask_byte((n % 16 == 15) ? pick_mask_byte() : 8'hff);

      wait_spans_drained();
      $display("%0d mask bytes in, %0d spans checked, %0d mask ends, up to %0d spans per byte",
               bytes_taken, spans_checked, masks_ended, most_spans);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
